### rtl/csbg_pkg.sv
package csbg_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_VIDEO_MODE         = 3'd0,
      CSR_BLANKING_LEVEL     = 3'd1,
      CSR_WHITE_LEVEL        = 3'd2,
      CSR_BURST_FIRST_SAMPLE = 3'd3,
      CSR_BURST_LAST_SAMPLE  = 3'd4,
      CSR_PHASE_STEP         = 3'd5,
      CSR_ONE_CYCLE_SAMPLES  = 3'd6,
      CSR_TWO_CYCLE_SAMPLES  = 3'd7
   } csbg_csr_index_type;

   // envelope region of a sample inside the burst window
   typedef enum logic [1:0] {
      REGION_FLAT,
      REGION_RISE,
      REGION_FALL
   } csbg_region_type;

   typedef struct packed {
      logic        video_mode;
      logic [15:0] blanking_level;
      logic [15:0] white_level;
      logic [11:0] burst_first_sample;
      logic [11:0] burst_last_sample;
      logic [31:0] phase_step;
      logic [7:0]  one_cycle_samples;
      logic [8:0]  two_cycle_samples;
   } csbg_cfg_type;

   // side data handed from the phase pipe to the shaping pipe
   typedef struct packed {
      logic            in_win;
      csbg_region_type region;
      logic [13:0]     amp_mag;
      logic            amp_neg;
   } csbg_mid_type;

   localparam csbg_cfg_type CFG_RESET = '{
      video_mode:         1'b0,
      blanking_level:     16'd16384,
      white_level:        16'd53248,
      burst_first_sample: 12'd0,
      burst_last_sample:  12'd0,
      phase_step:         32'h4000_0000,
      one_cycle_samples:  8'd4,
      two_cycle_samples:  9'd8
   };

   // pal line sequence
   localparam logic [11:0] FIELD_PAIR_LINES  = 12'd625;
   localparam logic [11:0] ODD_FIELD_LINES   = 12'd314;
   localparam logic [31:0] PAL_LINE_STEP     = 32'd3228097420;
   localparam logic [31:0] PAL_OFFSET_EVEN   = 32'h6000_0000;
   localparam logic [31:0] PAL_OFFSET_ODD    = 32'hA000_0000;
   // ntsc burst sits a half cycle off the line phase
   localparam logic [1:0]  NTSC_BURST_QUARTERS = 2'd2;

   // amplitude: range/5 and range*3/14 by reciprocal, exact for 16-bit magnitudes
   localparam logic [19:0] AMP_RECIP_NTSC = 20'd838864;
   localparam logic [19:0] AMP_RECIP_PAL  = 20'd898782;
   localparam int          AMP_SHIFT      = 22;

   // ramp fraction: divide by three, exact below 2^17
   localparam logic [16:0] DIV3_MUL    = 17'd43691;
   localparam int          DIV3_SHIFT  = 17;
   // a ramp product of RAMP_SAT_UNITS or more whole phase turns saturates
   localparam logic [12:0] RAMP_SAT_UNITS = 13'd3;

   localparam logic [15:0] ENV_ONE = 16'd32768;

   // q30 odd polynomial for sin(pi/2 * u)
   localparam logic [63:0] POLY_A1 = 64'd1686629713;
   localparam logic [63:0] POLY_A3 = 64'd693598668;
   localparam logic [63:0] POLY_A5 = 64'd85569305;
   localparam logic [63:0] POLY_A7 = 64'd5026996;
   localparam logic [63:0] POLY_A9 = 64'd172272;
   localparam logic [63:0] Q30_ONE = 64'd1073741824;

   // quarter-wave entry k of a table with 2^qbits steps per quarter, q1.15 magnitude
   function automatic logic [14:0] sine_mag(input int k, input int qbits);
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] mag;
      u   = 64'(k) << (30 - qbits);
      u2  = (u * u) >> 30;
      t   = POLY_A7 - ((u2 * POLY_A9) >> 30);
      t   = POLY_A5 - ((u2 * t) >> 30);
      t   = POLY_A3 - ((u2 * t) >> 30);
      t   = POLY_A1 - ((u2 * t) >> 30);
      s   = (u * t) >> 30;
      mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      return mag[14:0];
   endfunction

endpackage

### rtl/csbg_if.sv
interface csbg_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] field_index;
   logic [9:0]  line_index;
   logic [11:0] sample_index;

   modport source (output valid, output field_index, output line_index,
                   output sample_index, input ready);
   modport sink (input valid, input field_index, input line_index,
                 input sample_index, output ready);
endinterface

interface csbg_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] burst_value;
   logic        write_enable;

   modport source (output valid, output burst_value, output write_enable, input ready);
   modport sink (input valid, input burst_value, input write_enable, output ready);
endinterface

interface csbg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/color_burst_sample_generator.sv
// channel  dir  payload                                  accepted when
// req_ch   in   field_index, line_index, sample_index    valid && ready
// rsp_ch   out  burst_value, write_enable                valid && ready
// csr_ch   in   index (register number), data            valid && ready, ready always high
//
// one item per cycle sustained while results are taken; from accept to result an item passes
// through three phase stages, table read, envelope multiply, product multiply and output
// each stage keeps its own valid bit and advances when it is empty or the next
// one moves, so a stalled result lets earlier stages fill up behind it
// reset is synchronous active high: clears valid bits and loads default registers
module color_burst_sample_generator #(
   parameter int SINE_TABLE_BITS = 10
) (
   input logic      clock,
   input logic      reset,
   csbg_req_if.sink   req_ch,
   csbg_rsp_if.source rsp_ch,
   csbg_csr_if.sink   csr_ch
);
   import csbg_pkg::*;

   // configuration registers; the user must write them only while idle, the block does not enforce it
   csbg_cfg_type cfg_in, cfg_ff;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csbg_csr_index_type'(csr_ch.index))
            CSR_VIDEO_MODE:         cfg_in.video_mode         = csr_ch.data[0];
            CSR_BLANKING_LEVEL:     cfg_in.blanking_level     = csr_ch.data[15:0];
            CSR_WHITE_LEVEL:        cfg_in.white_level        = csr_ch.data[15:0];
            CSR_BURST_FIRST_SAMPLE: cfg_in.burst_first_sample = csr_ch.data[11:0];
            CSR_BURST_LAST_SAMPLE:  cfg_in.burst_last_sample  = csr_ch.data[11:0];
            CSR_PHASE_STEP:         cfg_in.phase_step         = csr_ch.data;
            CSR_ONE_CYCLE_SAMPLES:  cfg_in.one_cycle_samples  = csr_ch.data[7:0];
            CSR_TWO_CYCLE_SAMPLES:  cfg_in.two_cycle_samples  = csr_ch.data[8:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // phase pipe to shaping pipe
   logic                       mid_valid, mid_ready;
   logic [SINE_TABLE_BITS-1:0] sine_idx, cos_idx;
   csbg_mid_type               mid;

   // stages a-c: window and region, products, table indexes
   csbg_phase #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_phase (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_ch.valid),
      .in_ready     (req_ch.ready),
      .field_index  (req_ch.field_index),
      .line_index   (req_ch.line_index),
      .sample_index (req_ch.sample_index),
      .out_valid    (mid_valid),
      .out_ready    (mid_ready),
      .sine_idx     (sine_idx),
      .cos_idx      (cos_idx),
      .mid          (mid)
   );

   // stages d-g: table reads, envelope, product, clamp into the result register
   csbg_shape #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_shape (
      .clock          (clock),
      .reset          (reset),
      .blanking_level (cfg_ff.blanking_level),
      .in_valid       (mid_valid),
      .in_ready       (mid_ready),
      .sine_idx       (sine_idx),
      .cos_idx        (cos_idx),
      .mid            (mid),
      .out_valid      (rsp_ch.valid),
      .out_ready      (rsp_ch.ready),
      .burst_value    (rsp_ch.burst_value),
      .write_enable   (rsp_ch.write_enable)
   );

   // outside the window the sample reads as zero
   a_out_window_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.write_enable |-> rsp_ch.burst_value == 16'd0)
      else $error("nonzero sample outside burst window");

   // a free result register frees the whole pipe
   a_ready_when_drained : assert property (@(posedge clock) disable iff (reset)
      !rsp_ch.valid || rsp_ch.ready |-> req_ch.ready)
      else $error("input held off with result slot free");

   a_step_written : assert property (@(posedge clock) disable iff (reset)
      csr_ch.valid && csr_ch.index == CSR_PHASE_STEP |=> cfg_ff.phase_step == $past(csr_ch.data))
      else $error("phase step write lost");

endmodule

### rtl/csbg_sine_rom.sv
module csbg_sine_rom #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [SINE_TABLE_BITS-1:0] phase_idx,
   output logic signed [15:0]         value_ff
);
   import csbg_pkg::*;

   localparam int QBITS = SINE_TABLE_BITS - 2;
   localparam int QSIZE = 1 << QBITS;

   logic [14:0]        tbl [QSIZE+1];
   logic [1:0]         quad;
   logic [QBITS-1:0]   qpos;
   logic [QBITS:0]     addr;
   logic [14:0]        mag;
   logic signed [15:0] value_in;

   for (genvar gi = 0; gi <= QSIZE; gi++) begin : g_tbl
      assign tbl[gi] = sine_mag(gi, QBITS);
   end

   assign quad = phase_idx[SINE_TABLE_BITS-1 -: 2];
   assign qpos = phase_idx[QBITS-1:0];

   // odd quadrants run the quarter wave backwards
   always_comb begin
      if (quad[0]) begin
         addr = (QBITS+1)'(QSIZE) - {1'b0, qpos};
      end else begin
         addr = {1'b0, qpos};
      end
      mag = tbl[addr];
      if (quad[1]) begin
         value_in = -$signed({1'b0, mag});
      end else begin
         value_in = $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= value_in;
      end
   end

endmodule

### rtl/csbg_phase.sv
module csbg_phase #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  csbg_pkg::csbg_cfg_type     cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [15:0]                field_index,
   input  logic [9:0]                 line_index,
   input  logic [11:0]                sample_index,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [SINE_TABLE_BITS-1:0] sine_idx,
   output logic [SINE_TABLE_BITS-1:0] cos_idx,
   output csbg_pkg::csbg_mid_type     mid
);
   import csbg_pkg::*;

   localparam int TB       = SINE_TABLE_BITS;
   localparam int RAMP_LSB = 33 - TB;
   localparam logic [TB-1:0] IDX_QUARTER = TB'(1) << (TB - 2);
   localparam logic [TB-1:0] IDX_HALF    = TB'(1) << (TB - 1);

   // stage handshake
   logic a_v_ff, b_v_ff, c_v_ff;
   logic adv_a, adv_b, adv_c;

   assign adv_c    = !c_v_ff || out_ready;
   assign adv_b    = !b_v_ff || adv_c;
   assign adv_a    = !a_v_ff || adv_b;
   assign in_ready = adv_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         if (adv_a) begin
            a_v_ff <= in_valid;
         end
         if (adv_b) begin
            b_v_ff <= a_v_ff;
         end
         if (adv_c) begin
            c_v_ff <= b_v_ff;
         end
      end
   end

   // stage a: window, envelope region, line count, amplitude magnitude
   logic signed [13:0] samp_s, rise_lo, fall_lo, diff;
   logic [12:0]        rise_hi, fall_hi;
   logic [16:0]        range;
   logic [11:0]        a_samp_in, a_samp_ff;
   logic [12:0]        a_p_in, a_p_ff;
   logic [11:0]        a_n_in, a_n_ff;
   logic [1:0]         a_ntsc_in, a_ntsc_ff;
   logic [15:0]        a_amag_in, a_amag_ff;
   logic               a_win_in, a_win_ff;
   logic               a_aneg_in, a_aneg_ff;
   csbg_region_type    a_region_in, a_region_ff;

   always_comb begin
      samp_s     = $signed({2'b00, sample_index});
      rise_lo    = $signed({2'b00, cfg.burst_first_sample})
                   - $signed({5'b0, cfg.two_cycle_samples});
      rise_hi    = {1'b0, cfg.burst_first_sample} + {5'b0, cfg.one_cycle_samples};
      fall_lo    = $signed({2'b00, cfg.burst_last_sample})
                   - $signed({6'b0, cfg.one_cycle_samples});
      fall_hi    = {1'b0, cfg.burst_last_sample} + {4'b0, cfg.two_cycle_samples};
      a_win_in   = (samp_s >= rise_lo) && ({1'b0, sample_index} < fall_hi);
      if ({1'b0, sample_index} < rise_hi) begin
         a_region_in = REGION_RISE;
         diff        = samp_s - rise_lo;
      end else if (samp_s >= fall_lo) begin
         a_region_in = REGION_FALL;
         diff        = samp_s - fall_lo;
      end else begin
         a_region_in = REGION_FLAT;
         diff        = '0;
      end
      a_p_in    = diff[12:0];
      a_samp_in = sample_index;
      a_n_in    = 12'(field_index[2:1]) * FIELD_PAIR_LINES
                  + (field_index[0] ? ODD_FIELD_LINES : 12'd0)
                  + {2'b00, line_index};
      a_ntsc_in = 2'(field_index[1:0] * 2'd3) + {line_index[0], 1'b0}
                  + NTSC_BURST_QUARTERS;
      range     = {1'b0, cfg.white_level} - {1'b0, cfg.blanking_level};
      a_aneg_in = range[16];
      a_amag_in = range[16] ? 16'(-range) : range[15:0];
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_samp_ff   <= a_samp_in;
         a_p_ff      <= a_p_in;
         a_n_ff      <= a_n_in;
         a_ntsc_ff   <= a_ntsc_in;
         a_amag_ff   <= a_amag_in;
         a_win_ff    <= a_win_in;
         a_aneg_ff   <= a_aneg_in;
         a_region_ff <= a_region_in;
      end
   end

   // stage b: the products
   logic [31:0]     b_lin_in, b_lin_ff;
   logic [44:0]     b_rp_in, b_rp_ff;
   logic [31:0]     b_pal_in, b_pal_ff;
   logic [35:0]     b_amp_in, b_amp_ff;
   logic            b_n0_ff, b_win_ff, b_aneg_ff;
   logic [1:0]      b_ntsc_ff;
   csbg_region_type b_region_ff;

   always_comb begin
      b_lin_in = 32'(a_samp_ff) * cfg.phase_step;
      b_rp_in  = 45'(a_p_ff) * 45'(cfg.phase_step);
      b_pal_in = 32'(a_n_ff) * PAL_LINE_STEP;
      b_amp_in = 36'(a_amag_ff) * 36'(cfg.video_mode ? AMP_RECIP_PAL : AMP_RECIP_NTSC);
   end

   always_ff @(posedge clock) begin
      if (adv_b) begin
         b_lin_ff    <= b_lin_in;
         b_rp_ff     <= b_rp_in;
         b_pal_ff    <= b_pal_in;
         b_amp_ff    <= b_amp_in;
         b_n0_ff     <= a_n_ff[0];
         b_ntsc_ff   <= a_ntsc_ff;
         b_win_ff    <= a_win_ff;
         b_aneg_ff   <= a_aneg_ff;
         b_region_ff <= a_region_ff;
      end
   end

   // stage c: burst phase and ramp phase down to table indexes
   logic [31:0]     line_phase, phase;
   logic [TB:0]     ramp_q;
   logic [TB+17:0]  ramp_qm;
   logic [TB-1:0]   ramp_div;
   logic            ramp_sat;
   logic [TB-1:0]   c_sine_in, c_sine_ff;
   logic [TB-1:0]   c_cos_in, c_cos_ff;
   csbg_mid_type    c_mid_in, c_mid_ff;

   always_comb begin
      if (cfg.video_mode) begin
         line_phase = b_pal_ff + (b_n0_ff ? PAL_OFFSET_ODD : PAL_OFFSET_EVEN);
      end else begin
         line_phase = {b_ntsc_ff, 30'b0};
      end
      phase     = b_lin_ff + line_phase;
      c_sine_in = phase[31 -: TB];

      // only the top table bits of t/2 + quarter are needed
      ramp_sat = b_rp_ff[44:32] >= RAMP_SAT_UNITS;
      ramp_q   = b_rp_ff[RAMP_LSB +: TB+1];
      ramp_qm  = (TB+18)'(ramp_q) * (TB+18)'(DIV3_MUL);
      ramp_div = ramp_sat ? IDX_HALF : ramp_qm[DIV3_SHIFT +: TB];
      c_cos_in = ramp_div + IDX_QUARTER;

      c_mid_in.in_win  = b_win_ff;
      c_mid_in.region  = b_region_ff;
      c_mid_in.amp_mag = b_amp_ff[AMP_SHIFT +: 14];
      c_mid_in.amp_neg = b_aneg_ff;
   end

   always_ff @(posedge clock) begin
      if (adv_c) begin
         c_sine_ff <= c_sine_in;
         c_cos_ff  <= c_cos_in;
         c_mid_ff  <= c_mid_in;
      end
   end

   assign out_valid = c_v_ff;
   assign sine_idx  = c_sine_ff;
   assign cos_idx   = c_cos_ff;
   assign mid       = c_mid_ff;

endmodule

### rtl/csbg_shape.sv
module csbg_shape #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [15:0]                blanking_level,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [SINE_TABLE_BITS-1:0] sine_idx,
   input  logic [SINE_TABLE_BITS-1:0] cos_idx,
   input  csbg_pkg::csbg_mid_type     mid,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [15:0]                burst_value,
   output logic                       write_enable
);
   import csbg_pkg::*;

   logic d_v_ff, e_v_ff, f_v_ff, g_v_ff;
   logic adv_d, adv_e, adv_f, adv_g;

   assign adv_g    = !g_v_ff || out_ready;
   assign adv_f    = !f_v_ff || adv_g;
   assign adv_e    = !e_v_ff || adv_f;
   assign adv_d    = !d_v_ff || adv_e;
   assign in_ready = adv_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
      end else begin
         if (adv_d) begin
            d_v_ff <= in_valid;
         end
         if (adv_e) begin
            e_v_ff <= d_v_ff;
         end
         if (adv_f) begin
            f_v_ff <= e_v_ff;
         end
         if (adv_g) begin
            g_v_ff <= f_v_ff;
         end
      end
   end

   // stage d: table reads
   logic signed [15:0] sin_ff, cos_ff;
   csbg_mid_type       d_mid_ff;

   csbg_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine_rom (
      .clock     (clock),
      .enable    (adv_d),
      .phase_idx (sine_idx),
      .value_ff  (sin_ff)
   );

   csbg_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_cos_rom (
      .clock     (clock),
      .enable    (adv_d),
      .phase_idx (cos_idx),
      .value_ff  (cos_ff)
   );

   always_ff @(posedge clock) begin
      if (adv_d) begin
         d_mid_ff <= mid;
      end
   end

   // stage e: envelope times amplitude, sine magnitude
   logic signed [16:0] env_sum;
   logic [15:0]        env_in;
   logic [29:0]        e_ae_in, e_ae_ff;
   logic [14:0]        e_smag_in, e_smag_ff;
   logic               e_neg_in, e_neg_ff, e_win_ff;

   always_comb begin
      case (d_mid_ff.region)
         REGION_RISE: env_sum = $signed({1'b0, ENV_ONE}) - $signed({cos_ff[15], cos_ff});
         REGION_FALL: env_sum = $signed({1'b0, ENV_ONE}) + $signed({cos_ff[15], cos_ff});
         default:     env_sum = $signed({ENV_ONE, 1'b0});
      endcase
      // ramp sums are positive, so the halving truncates like a divide
      env_in    = (d_mid_ff.region == REGION_FLAT) ? ENV_ONE : env_sum[16:1];
      e_ae_in   = 30'(d_mid_ff.amp_mag) * 30'(env_in);
      e_smag_in = sin_ff[15] ? 15'(-sin_ff) : sin_ff[14:0];
      e_neg_in  = d_mid_ff.amp_neg ^ sin_ff[15];
   end

   always_ff @(posedge clock) begin
      if (adv_e) begin
         e_ae_ff   <= e_ae_in;
         e_smag_ff <= e_smag_in;
         e_neg_ff  <= e_neg_in;
         e_win_ff  <= d_mid_ff.in_win;
      end
   end

   // stage f: full product, magnitude truncation
   logic [44:0] prod;
   logic [13:0] f_mag_ff;
   logic        f_neg_ff, f_win_ff;

   assign prod = 45'(e_ae_ff) * 45'(e_smag_ff);

   always_ff @(posedge clock) begin
      if (adv_f) begin
         f_mag_ff <= prod[43:30];
         f_neg_ff <= e_neg_ff;
         f_win_ff <= e_win_ff;
      end
   end

   // stage g: offset from blanking and clamp
   logic signed [17:0] level;
   logic [15:0]        g_value_in, g_value_ff;
   logic               g_we_ff;

   always_comb begin
      if (f_neg_ff) begin
         level = $signed({2'b00, blanking_level}) - $signed({4'b0, f_mag_ff});
      end else begin
         level = $signed({2'b00, blanking_level}) + $signed({4'b0, f_mag_ff});
      end
      if (!f_win_ff || level[17]) begin
         g_value_in = '0;
      end else if (level[16]) begin
         g_value_in = '1;
      end else begin
         g_value_in = level[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv_g) begin
         g_value_ff <= g_value_in;
         g_we_ff    <= f_win_ff;
      end
   end

   assign out_valid    = g_v_ff;
   assign burst_value  = g_value_ff;
   assign write_enable = g_we_ff;

   a_env_bound : assert property (@(posedge clock) disable iff (reset)
      d_v_ff |-> env_in <= ENV_ONE)
      else $error("envelope above unity");

endmodule

### dv/color_burst_sample_generator_tb.sv
module color_burst_sample_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csbg_pkg::*;

   // sine table resolution of the block under test
   localparam int TABLE_BITS = 10;

   // q30 odd polynomial for a quarter sine wave
   localparam logic [63:0] SIN_K1  = 64'd1686629713;
   localparam logic [63:0] SIN_K3  = 64'd693598668;
   localparam logic [63:0] SIN_K5  = 64'd85569305;
   localparam logic [63:0] SIN_K7  = 64'd5026996;
   localparam logic [63:0] SIN_K9  = 64'd172272;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   // burst phase offsets as cycle fractions
   localparam logic [31:0] NTSC_HALF_CYCLE  = 32'h8000_0000;
   localparam logic [31:0] PAL_LINE_ADVANCE = 32'd3228097420;
   localparam logic [31:0] PAL_SWING_EVEN   = 32'h6000_0000;
   localparam logic [31:0] PAL_SWING_ODD    = 32'hA000_0000;

   localparam int ENVELOPE_FULL = 32768;

   localparam logic MODE_NTSC = 1'b0;
   localparam logic MODE_PAL  = 1'b1;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 110;
   // cycles to let the seven-stage pipe settle at the end
   localparam int SETTLE_CYCLES   = 10;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [15:0] field_idx;
      logic [9:0]  line_idx;
      logic [11:0] sample_idx;
   } burst_req_type;

   typedef struct {
      logic [15:0] value;
      logic        write_en;
   } burst_sample_type;

   typedef struct {
      logic        mode;
      logic [15:0] blank;
      logic [15:0] white;
      logic [11:0] first;
      logic [11:0] last;
      logic [31:0] step;
      logic [7:0]  one_cyc;
      logic [8:0]  two_cyc;
   } burst_cfg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csbg_req_if req_ch();
   csbg_rsp_if rsp_ch();
   csbg_csr_if csr_ch();

   color_burst_sample_generator #(
      .SINE_TABLE_BITS(TABLE_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow of the block's registers, updated on each accepted write
   burst_cfg_type    burst_cfg;
   burst_req_type    pending_reqs[$];
   burst_sample_type expected_samples[$];
   burst_req_type    taken_req;
   burst_sample_type want;
   int               fail_count = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;

   always #10 clock = ~clock;

   // q1.15 sine of a 32-bit cycle fraction via the quarter-wave polynomial
   function automatic int sine_q15(input logic [31:0] phase);
      logic [31:0] idx;
      logic [1:0]  quad;
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] mag;
      idx  = phase >> (32 - TABLE_BITS);
      quad = 2'(idx >> (TABLE_BITS - 2));
      u    = 64'(idx & ((32'd1 << (TABLE_BITS - 2)) - 32'd1)) << (30 - (TABLE_BITS - 2));
      if (quad[0]) begin
         u = ONE_Q30 - u;
      end
      u2  = (u * u) >> 30;
      t   = SIN_K7 - ((u2 * SIN_K9) >> 30);
      t   = SIN_K5 - ((u2 * t) >> 30);
      t   = SIN_K3 - ((u2 * t) >> 30);
      t   = SIN_K1 - ((u2 * t) >> 30);
      s   = (u * t) >> 30;
      mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      return quad[1] ? -int'(mag) : int'(mag);
   endfunction

   // cos(pi * pos * step / 3), fraction saturating at one
   function automatic int ramp_cos(input logic [31:0] step, input int pos);
      logic [63:0] frac;
      frac = (64'(pos) * 64'(step)) / 64'd3;
      if (frac > 64'h1_0000_0000) begin
         frac = 64'h1_0000_0000;
      end
      return sine_q15(32'((frac >> 1) + 64'h4000_0000));
   endfunction

   // composite burst sample for one position under the given settings
   function automatic burst_sample_type predict_burst(input burst_cfg_type c,
                                                      input burst_req_type r);
      int               s;
      int               win_lo;
      int               win_hi;
      int               rise_hi;
      int               fall_lo;
      int               span;
      int               amp;
      int               env;
      int               sn;
      int               value;
      logic [2:0]       f;
      logic [31:0]      n;
      logic [31:0]      phase;
      longint           prod;
      burst_sample_type res;
      s       = int'(r.sample_idx);
      win_lo  = int'(c.first) - int'(c.two_cyc);
      win_hi  = int'(c.last) + int'(c.two_cyc);
      rise_hi = int'(c.first) + int'(c.one_cyc);
      fall_lo = int'(c.last) - int'(c.one_cyc);
      if (s < win_lo || s >= win_hi) begin
         res.value    = '0;
         res.write_en = 1'b0;
         return res;
      end
      span  = int'(c.white) - int'(c.blank);
      phase = 32'(r.sample_idx) * c.step;
      if (c.mode == MODE_NTSC) begin
         amp   = span / 5;
         // four-field sequence in quarter cycles, half cycle per odd line
         phase += (32'(r.field_idx) * 32'd3) << 30;
         phase += 32'(r.line_idx[0]) << 31;
         phase += NTSC_HALF_CYCLE;
      end else begin
         amp   = (span * 3) / 14;
         // absolute line count over the eight-field sequence
         f     = r.field_idx[2:0];
         n     = 32'(f >> 1) * 32'd625 + 32'(f[0]) * 32'd313 + 32'(r.line_idx) + 32'(f[0]);
         phase += n * PAL_LINE_ADVANCE;
         phase += n[0] ? PAL_SWING_ODD : PAL_SWING_EVEN;
      end
      // rise wins where rise and fall overlap
      if (s < rise_hi) begin
         env = (ENVELOPE_FULL - ramp_cos(c.step, s - win_lo)) / 2;
      end else if (s >= fall_lo) begin
         env = (ENVELOPE_FULL + ramp_cos(c.step, s - fall_lo)) / 2;
      end else begin
         env = ENVELOPE_FULL;
      end
      sn   = sine_q15(phase);
      prod = longint'(amp) * longint'(env) * longint'(sn);
      // truncate toward zero on the magnitude
      if (prod < 0) begin
         value = int'(c.blank) - int'((-prod) >>> 30);
      end else begin
         value = int'(c.blank) + int'(prod >>> 30);
      end
      if (value < 0) begin
         value = 0;
      end
      if (value > 65535) begin
         value = 65535;
      end
      res.value    = 16'(value);
      res.write_en = 1'b1;
      return res;
   endfunction

   function automatic burst_req_type make_req(input int fld, input int ln, input int smp);
      burst_req_type r;
      r.field_idx  = 16'(fld);
      r.line_idx   = 10'(ln);
      r.sample_idx = 12'(smp);
      return r;
   endfunction

   // mostly around the burst window, sometimes anywhere on the line
   function automatic int pick_sample(input burst_cfg_type c);
      int lo;
      int hi;
      lo = int'(c.first) - int'(c.two_cyc) - 3;
      hi = int'(c.last) + int'(c.two_cyc) + 2;
      if (lo < 0) begin
         lo = 0;
      end
      if (hi > 4095) begin
         hi = 4095;
      end
      if (lo > hi || $urandom_range(3) == 0) begin
         return $urandom_range(4095);
      end
      return $urandom_range(hi, lo);
   endfunction

   function automatic burst_cfg_type rand_cfg();
      burst_cfg_type c;
      int            end_pos;
      c.mode  = 1'($urandom_range(1));
      c.blank = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20000, 12000));
      c.white = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(60000, 45000));
      c.first = 12'($urandom_range(4095));
      end_pos = int'(c.first) + $urandom_range(400, 40);
      if (end_pos > 4095) begin
         end_pos = 4095;
      end
      c.last    = ($urandom_range(3) == 0) ? 12'($urandom_range(4095)) : 12'(end_pos);
      c.step    = $urandom;
      c.one_cyc = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6, 2));
      c.two_cyc = ($urandom_range(3) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(14, 6));
      return c;
   endfunction

   // one register write; returns right after the accepting edge
   task automatic write_reg(input csbg_csr_index_type idx, input logic [31:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_VIDEO_MODE:         burst_cfg.mode    = val[0];
         CSR_BLANKING_LEVEL:     burst_cfg.blank   = val[15:0];
         CSR_WHITE_LEVEL:        burst_cfg.white   = val[15:0];
         CSR_BURST_FIRST_SAMPLE: burst_cfg.first   = val[11:0];
         CSR_BURST_LAST_SAMPLE:  burst_cfg.last    = val[11:0];
         CSR_PHASE_STEP:         burst_cfg.step    = val;
         CSR_ONE_CYCLE_SAMPLES:  burst_cfg.one_cyc = val[7:0];
         CSR_TWO_CYCLE_SAMPLES:  burst_cfg.two_cyc = val[8:0];
         default: ;
      endcase
   endtask

   task automatic load_cfg(input burst_cfg_type c);
      write_reg(CSR_VIDEO_MODE, 32'(c.mode));
      write_reg(CSR_BLANKING_LEVEL, 32'(c.blank));
      write_reg(CSR_WHITE_LEVEL, 32'(c.white));
      write_reg(CSR_BURST_FIRST_SAMPLE, 32'(c.first));
      write_reg(CSR_BURST_LAST_SAMPLE, 32'(c.last));
      write_reg(CSR_PHASE_STEP, c.step);
      write_reg(CSR_ONE_CYCLE_SAMPLES, 32'(c.one_cyc));
      write_reg(CSR_TWO_CYCLE_SAMPLES, 32'(c.two_cyc));
      csr_ch.valid <= 1'b0;
   endtask

   // wait until every queued item went in and every sample came back,
   // then line up on a rising edge for the next register writes
   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_ch.valid || expected_samples.size() != 0);
      @(posedge clock);
   endtask

   // driver: presents queued items, holds them until taken, predicts on accept
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid        <= 1'b0;
         req_ch.field_index  <= '0;
         req_ch.line_index   <= '0;
         req_ch.sample_index <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            taken_req.field_idx  = req_ch.field_index;
            taken_req.line_idx   = req_ch.line_index;
            taken_req.sample_idx = req_ch.sample_index;
            expected_samples.push_back(predict_burst(burst_cfg, taken_req));
         end
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            taken_req = pending_reqs.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.field_index  <= taken_req.field_idx;
            req_ch.line_index   <= taken_req.line_idx;
            req_ch.sample_index <= taken_req.sample_idx;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: checks each accepted sample against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected sample: burst_value %0d write_enable %0b",
                      rsp_ch.burst_value, rsp_ch.write_enable);
               fail_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_ch.burst_value !== want.value) begin
                  $error("burst_value mismatch: expected %0d, actual %0d",
                         want.value, rsp_ch.burst_value);
                  fail_count++;
               end
               if (rsp_ch.write_enable !== want.write_en) begin
                  $error("write_enable mismatch: expected %0b, actual %0b",
                         want.write_en, rsp_ch.write_enable);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      burst_cfg_type cfg;
      // register port idles until the first write
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= CSR_VIDEO_MODE;
      csr_ch.data         <= '0;
      // shadow starts at the reset values
      burst_cfg = '{mode: MODE_NTSC, blank: 16'd16384, white: 16'd53248, first: 12'd0,
                    last: 12'd0, step: 32'h4000_0000, one_cyc: 8'd4, two_cyc: 9'd8};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ntsc at reset settings: window is samples 0..7, rise then fall,
      // fields walk the four-field sequence, lines alternate parity
      for (int k = 0; k < 9; k++) begin
         pending_reqs.push_back(make_req(k, k, k));
      end
      // largest field, line and sample index, far outside the window
      pending_reqs.push_back(make_req(16'hFFFF, 10'h3FF, 12'hFFF));
      drain();

      // pal swinging burst, steep ramp so the ramp fraction saturates
      write_reg(CSR_VIDEO_MODE, 32'(MODE_PAL));
      write_reg(CSR_PHASE_STEP, 32'h8000_0000);
      csr_ch.valid <= 1'b0;
      for (int k = 0; k < 8; k++) begin
         pending_reqs.push_back(make_req(k, k + 1, k));
      end
      pending_reqs.push_back(make_req(16'hFFFF, 10'h3FF, 3));
      pending_reqs.push_back(make_req(8, 0, 12'hFFF));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            // typical ntsc line
            0: cfg = '{mode: MODE_NTSC, blank: 16'd16384, white: 16'd53248, first: 12'd100,
                       last: 12'd300, step: 32'h43E0_F83E, one_cyc: 8'd4, two_cyc: 9'd8};
            // typical pal line
            1: cfg = '{mode: MODE_PAL, blank: 16'd16384, white: 16'd53248, first: 12'd200,
                       last: 12'd260, step: 32'h5440_0000, one_cyc: 8'd5, two_cyc: 9'd10};
            // widest window, full range, longest ramps, clamps at zero
            2: cfg = '{mode: MODE_PAL, blank: 16'd0, white: 16'hFFFF, first: 12'd0,
                       last: 12'hFFF, step: 32'hFFFF_FFFF, one_cyc: 8'hFF, two_cyc: 9'h1FF};
            // white below blanking inverts the burst; rise and fall overlap
            3: cfg = '{mode: MODE_NTSC, blank: 16'hFFFF, white: 16'd0, first: 12'd2000,
                       last: 12'd1990, step: 32'd0, one_cyc: 8'd0, two_cyc: 9'h1FF};
            default: cfg = rand_cfg();
         endcase
         load_cfg(cfg);

         case (idle_mode_type'(p % 4))
            IDLE_NONE: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            IDLE_SEND: begin
               send_idle_pct  = 85;
               recv_stall_pct = 0;
            end
            IDLE_RECV: begin
               send_idle_pct  = 0;
               recv_stall_pct = 85;
            end
            default: begin
               send_idle_pct  = 18;
               recv_stall_pct = 18;
            end
         endcase

         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            pending_reqs.push_back(make_req($urandom_range(16'hFFFF), $urandom_range(10'h3FF),
                                            pick_sample(burst_cfg)));
         end
         drain();
      end

      // anything arriving now has no prediction and is flagged
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
